/* rtl/sha5_pkg.sv */
package sha5_pkg;

  // Hash state and message block as packed word arrays, word 0 first.
  typedef logic [0:7][63:0]  hash_t;
  typedef logic [0:15][63:0] block_t;

  localparam int ROUNDS    = 80;
  localparam int RND_W     = 7;
  localparam int BLK_WORDS = 16;

  localparam hash_t HASH_IV = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

/* rtl/sha5_compress.sv */
module sha5_compress (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  sha5_pkg::hash_t  hash_in,
  input  sha5_pkg::block_t block_in,
  output logic           done,
  output sha5_pkg::hash_t  hash_sum
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [sha5_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  sha5_pkg::hash_t          v_r, v_nxt;
  sha5_pkg::block_t         w_r, w_nxt;

  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] ch;
  logic [63:0] maj;
  logic [63:0] w_new;

  // One round per cycle: working variables and a sliding 16-word schedule window.
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sha5_pkg::big_sigma1(v_r[4]) + ch + sha5_pkg::ROUND_K[rnd_r] + w_r[0];
    t2    = sha5_pkg::big_sigma0(v_r[0]) + maj;
    w_new = sha5_pkg::small_sigma1(w_r[14]) + w_r[9] + sha5_pkg::small_sigma0(w_r[1]) + w_r[0];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rnd_nxt  = rnd_r;
    v_nxt    = v_r;
    w_nxt    = w_r;

    if (start) begin
      busy_nxt = 1'b1;
      rnd_nxt  = '0;
      v_nxt    = hash_in;
      w_nxt    = block_in;
    end else if (busy_r) begin
      v_nxt = {t1 + t2, v_r[0], v_r[1], v_r[2], v_r[3] + t1, v_r[4], v_r[5], v_r[6]};
      for (int i = 0; i < sha5_pkg::BLK_WORDS - 1; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[sha5_pkg::BLK_WORDS - 1] = w_new;
      rnd_nxt = rnd_r + 1'b1;
      if (rnd_r == sha5_pkg::RND_W'(sha5_pkg::ROUNDS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  // Feed-forward: the chaining value plus the final working variables.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_sum[i] = hash_in[i] + v_r[i];
    end
  end

  assign done = done_r;

endmodule

/* rtl/sha512_stream_hasher.sv */
// A word that does not complete a 128-byte block is taken without a stall.
// A word that completes a block stalls the input while it is compressed: load, 80 rounds
// on the single round unit, and the feed-forward add; no new word is taken meanwhile.
// A last word adds one padding write per remaining block slot and one or two compressions,
// then the 8 digest words leave one per cycle unless stalled; then a new message starts.
// Reset (rst_n low, synchronous) loads the initial hash and clears counts and length.
module sha512_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_msg_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic        out_digest_last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_PADW = 3'd2;
  localparam logic [2:0] S_PADZ = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       ret_r, ret_nxt;
  logic             start_r, start_nxt;
  logic             spill_r, spill_nxt;
  logic [6:0]       count_r, count_nxt;
  logic [63:0]      len_lo_r, len_lo_nxt;
  logic [63:0]      len_hi_r, len_hi_nxt;
  logic [2:0]       oidx_r, oidx_nxt;
  sha5_pkg::hash_t  hash_r, hash_nxt;
  sha5_pkg::block_t blk_r;

  logic        blk_we;
  logic [3:0]  blk_addr;
  logic [63:0] blk_data;
  logic [3:0]  nbytes;
  logic [6:0]  add_bits;
  logic [64:0] len_sum;
  logic [63:0] kept;
  logic        core_done;
  sha5_pkg::hash_t core_sum;

  assign blk_addr = count_r[6:3];

  // Byte count of the word, and the last word trimmed with its 0x80 pad byte.
  always_comb begin
    if (!in_last_item || in_valid_bytes > 4'd8) begin
      nbytes = 4'd8;
    end else begin
      nbytes = in_valid_bytes;
    end
    add_bits = {nbytes, 3'b000};
    len_sum  = {1'b0, len_lo_r} + {58'd0, add_bits};
    kept     = (in_msg_word & ~({64{1'b1}} >> {nbytes[2:0], 3'b000}))
             | (64'h80 << {3'(3'd7 - nbytes[2:0]), 3'b000});
  end

  // Sequencer: buffering, padding, compression hand-off and digest output.
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    start_nxt  = 1'b0;
    spill_nxt  = spill_r;
    count_nxt  = count_r;
    len_lo_nxt = len_lo_r;
    len_hi_nxt = len_hi_r;
    oidx_nxt   = oidx_r;
    hash_nxt   = hash_r;
    blk_we     = 1'b0;
    blk_data   = in_msg_word;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          blk_we     = 1'b1;
          count_nxt  = count_r + 7'd8;
          len_lo_nxt = len_sum[63:0];
          len_hi_nxt = len_hi_r + {63'd0, len_sum[64]};
          if (!in_last_item) begin
            if (count_r == 7'd120) begin
              start_nxt = 1'b1;
              ret_nxt   = S_IDLE;
              state_nxt = S_COMP;
            end
          end else if (nbytes == 4'd8) begin
            if (count_r == 7'd120) begin
              start_nxt = 1'b1;
              ret_nxt   = S_PADW;
              state_nxt = S_COMP;
            end else begin
              state_nxt = S_PADW;
            end
          end else begin
            blk_data  = kept;
            spill_nxt = (count_r == 7'd112);
            if (count_r == 7'd120) begin
              start_nxt = 1'b1;
              ret_nxt   = S_PADZ;
              state_nxt = S_COMP;
            end else begin
              state_nxt = S_PADZ;
            end
          end
        end
      end
      S_PADW: begin
        blk_we    = 1'b1;
        blk_data  = 64'h8000000000000000;
        count_nxt = count_r + 7'd8;
        spill_nxt = (count_r == 7'd112);
        if (count_r == 7'd120) begin
          start_nxt = 1'b1;
          ret_nxt   = S_PADZ;
          state_nxt = S_COMP;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        // Zero fill; the length goes in the last two words unless this block spills.
        blk_we    = 1'b1;
        count_nxt = count_r + 7'd8;
        if (!spill_r && blk_addr == 4'd14) begin
          blk_data = len_hi_r;
        end else if (!spill_r && blk_addr == 4'd15) begin
          blk_data = len_lo_r;
        end else begin
          blk_data = '0;
        end
        if (blk_addr == 4'd15) begin
          start_nxt = 1'b1;
          ret_nxt   = spill_r ? S_PADZ : S_OUT;
          spill_nxt = 1'b0;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (core_done) begin
          hash_nxt  = core_sum;
          state_nxt = ret_r;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (oidx_r == 3'd7) begin
            oidx_nxt   = '0;
            hash_nxt   = sha5_pkg::HASH_IV;
            count_nxt  = '0;
            len_lo_nxt = '0;
            len_hi_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      start_r  <= 1'b0;
      spill_r  <= 1'b0;
      count_r  <= '0;
      len_lo_r <= '0;
      len_hi_r <= '0;
      oidx_r   <= '0;
      hash_r   <= sha5_pkg::HASH_IV;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      start_r  <= start_nxt;
      spill_r  <= spill_nxt;
      count_r  <= count_nxt;
      len_lo_r <= len_lo_nxt;
      len_hi_r <= len_hi_nxt;
      oidx_r   <= oidx_nxt;
      hash_r   <= hash_nxt;
    end
  end

  // Block buffer, one word written per cycle while blk_we is high.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_r[blk_addr] <= blk_data;
    end
  end

  sha5_compress u_compress (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .hash_in  (hash_r),
    .block_in (blk_r),
    .done     (core_done),
    .hash_sum (core_sum)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = hash_r[oidx_r];
  assign out_digest_last = (oidx_r == 3'd7);

endmodule

/* tb/sha512_stream_hasher_tb.sv */
module sha512_stream_hasher_tb;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_WORDS  = 70;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  // One input word and one digest word as the testbench sees them.
  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        fin;
  } msg_word_t;

  typedef struct {
    logic [63:0] data;
    logic        fin;
  } digest_word_t;

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] START_HASH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_msg_word = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_word;
  logic        out_digest_last;

  // Words waiting to be sent and digest words waiting to be seen.
  msg_word_t    pending_words[$];
  digest_word_t expected_digests[$];
  msg_word_t    drv_word;

  // Running hash of the message seen so far.
  logic [63:0]  hash_acc [8];
  logic [63:0]  block_buf [16];
  int           block_fill;
  logic [127:0] msg_bits;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int digests_checked = 0;
  int words_taken = 0;
  int messages_done = 0;
  int cycle_count = 0;

  sha512_stream_hasher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_msg_word     (in_msg_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_acc[i] = START_HASH[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    block_fill = 0;
    msg_bits = '0;
  endfunction

  // Eighty rounds over the buffered block, folded into the running hash.
  function automatic void compress_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1;
    logic [63:0] t2;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 80; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7))
           + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
  endfunction

  function automatic void buffer_word(input logic [63:0] data);
    block_buf[block_fill] = data;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Absorb one accepted word; a final word pads the message and yields the digest.
  function automatic void sha512_absorb(input msg_word_t mw);
    int n;
    int idx;
    logic [63:0] kept;
    digest_word_t dw;
    if (!mw.fin) begin
      msg_bits = msg_bits + 128'd64;
      buffer_word(mw.data);
      return;
    end
    n = (mw.nbytes > 4'd8) ? 8 : int'(mw.nbytes);
    msg_bits = msg_bits + 128'(n * 8);
    if (n == 8) begin
      buffer_word(mw.data);
      buffer_word(64'h8000_0000_0000_0000);
    end else begin
      kept = (n == 0) ? 64'd0 : (mw.data & ~(64'hffff_ffff_ffff_ffff >> (8 * n)));
      kept = kept | (64'h80 << (56 - 8 * n));
      buffer_word(kept);
    end
    // The length needs the last two slots; spill into an extra block if they are taken.
    idx = block_fill;
    if (idx > 14) begin
      for (int i = idx; i < 16; i++) block_buf[i] = '0;
      compress_block();
      idx = 0;
    end
    for (int i = idx; i < 14; i++) block_buf[i] = '0;
    block_buf[14] = msg_bits[127:64];
    block_buf[15] = msg_bits[63:0];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.data = hash_acc[i];
      dw.fin = (i == 7);
      expected_digests.push_back(dw);
    end
    hash_restart();
  endfunction

  function automatic logic [63:0] rand_data();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'hffff_ffff_ffff_ffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Queue one message of body words plus a final word; returns the word count.
  function automatic int queue_message(input int body_words, input logic [3:0] tail_bytes);
    msg_word_t mw;
    for (int i = 0; i < body_words; i++) begin
      mw.data = rand_data();
      mw.nbytes = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
      mw.fin = 1'b0;
      pending_words.push_back(mw);
    end
    mw.data = rand_data();
    mw.nbytes = tail_bytes;
    mw.fin = 1'b1;
    pending_words.push_back(mw);
    return body_words + 1;
  endfunction

  // Random message shapes, weighted toward the padding boundaries near a full block.
  function automatic int queue_random_message();
    int body;
    logic [3:0] tail;
    case ($urandom_range(9))
      0, 1, 2, 3: body = $urandom_range(5);
      4, 5, 6:    body = 13 + $urandom_range(2) + 16 * $urandom_range(1);
      7, 8:       body = $urandom_range(12, 6);
      default:    body = $urandom_range(40, 16);
    endcase
    if ($urandom_range(3) == 0) tail = 4'($urandom_range(15));
    else if ($urandom_range(1) == 1) tail = 4'd8;
    else tail = 4'($urandom_range(7));
    return queue_message(body, tail);
  endfunction

  // Driver: keeps a stalled word steady and models every accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sha512_absorb(drv_word);
        words_taken++;
        if (drv_word.fin) messages_done++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_msg_word <= drv_word.data;
          in_valid_bytes <= drv_word.nbytes;
          in_last_item <= drv_word.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall and digest comparison.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_digests.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected digest word %h last %b", out_digest_word, out_digest_last);
        end else begin
          digest_word_t exp_dw;
          exp_dw = expected_digests.pop_front();
          digests_checked++;
          if (out_digest_word !== exp_dw.data || out_digest_last !== exp_dw.fin) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("digest word mismatch: expected %h last %b, got %h last %b",
                       exp_dw.data, exp_dw.fin, out_digest_word, out_digest_last);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Wait at a clock low phase until every word is taken and every digest has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() > 0 || in_valid || expected_digests.size() > 0);
  endtask

  initial begin
    int phase_words;
    int idle_send [4];
    int idle_recv [4];
    int dummy;
    idle_send = '{0, 83, 0, 31};
    idle_recv = '{0, 0, 83, 31};
    hash_restart();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed messages: empty, short "abc" with junk in the dropped bytes,
    // a count above eight on the final word, an ignored zero count mid-message,
    // and a final partial word that closes a full block.
    dummy = queue_message(0, 4'd0);
    pending_words.push_back('{64'h6162_63de_adbe_ef12, 4'd3, 1'b1});
    pending_words.push_back('{64'hffff_ffff_ffff_ffff, 4'd15, 1'b1});
    pending_words.push_back('{64'h0123_4567_89ab_cdef, 4'd0, 1'b0});
    pending_words.push_back('{64'hfedc_ba98_7654_3210, 4'd0, 1'b1});
    dummy = queue_message(15, 4'd5);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_send[ph];
      stall_pct = idle_recv[ph];
      phase_words = 0;
      while (phase_words < PHASE_WORDS) phase_words += queue_random_message();
      // The sender holds off at each phase boundary until all digests are back.
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d messages in %0d words, %0d digest words checked,",
             messages_done, words_taken, digests_checked);
    $display("under free flow, sender gaps, receiver stalls and both together");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
